/* hw/rtl/bwom_pkg.sv */
// Shared types, codes and helpers of the boundary window overlap matcher.
`timescale 1ns / 1ps
package bwom_pkg;

    localparam int CHROM_W     = 8;
    localparam int EXT_W       = 32;
    localparam int LANE_W      = 16;
    localparam int PAIR_W      = 32;
    localparam int ENTRY_NUM_W = 6;
    localparam int KIND_W      = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STRAND_FWD = 1'b0;
    localparam logic STRAND_REV = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_LEFT  = 2'd1,
        KIND_RIGHT = 2'd2,
        KIND_BOTH  = 2'd3
    } match_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } scan_state_t;

    // Per-cell control: write a new entry, or take the neighbor's entry.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    // Returns {right_event, left_event} for a match kind and read strand.
    function automatic logic [1:0] event_flags(input match_kind_t kind, input logic strand);
        logic lev;
        logic rev;
        lev = (kind == KIND_BOTH) || (kind == KIND_LEFT && strand == STRAND_FWD);
        rev = (kind == KIND_BOTH) || (kind == KIND_RIGHT && strand == STRAND_REV);
        return {rev, lev};
    endfunction

endpackage

/* hw/rtl/boundary_window_overlap_match_core.sv */
// Top level of the boundary window overlap matcher: entry ring, scan control, result register.
`timescale 1ns / 1ps
// Usage
//   Input stream (s_*): one transaction is a command. s_tuser = 0 loads a boundary
//   entry into the next free slot, s_tuser = 1 queries a read interval.
//   Result stream (m_*): a load answers with one transaction (m_tuser flags a
//   refused load on a full table). A query answers with one transaction per
//   matching entry of the read's chromosome in load order, or one of kind none;
//   m_tlast marks the final transaction of each command.
//   cfg_wr_en / cfg_wr_data write the window extension; write it while idle.
// Command flow
//   A load's result is registered and valid the next cycle after the
//   accept; loads can follow back to back while m_tready is high.
//   A query rotates the ring of TABLE_DEPTH cells once, one cell per cycle
//   while the result register is free, then closes the run in ST_FINISH
//   with its final result; the next command is taken only once the core
//   is back in ST_IDLE.
// Reset and stalls
//   aresetn (synchronous, active low) empties the table and zeroes the
//   extension; stored entries themselves are not cleared. While m_tready is
//   low with a result pending, the ring and the scan hold in place.
module boundary_window_overlap_match_core #(
    parameter int TABLE_DEPTH   = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,      // window_extension

    input  logic        s_tvalid,
    output logic        s_tready,
    // chromosome, plus_first, plus_last, minus_first, minus_last, read_begin,
    // read_end, read_strand, lane_number, pair_number (low bit up), zero padded
    input  logic [((bwom_pkg::CHROM_W + 6*POSITION_BITS + 1 + bwom_pkg::LANE_W
                   + bwom_pkg::PAIR_W + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic        s_tuser,          // command

    output logic        m_tvalid,
    input  logic        m_tready,
    // entry_number, match_kind, left_event, right_event, lane_out, pair_out
    output logic [63:0] m_tdata,
    output logic        m_tuser,          // table_full
    output logic        m_tlast           // last_result
);
    import bwom_pkg::*;

    localparam int P      = POSITION_BITS;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W  = CHROM_W + 4 * P;
    localparam int SUM_W  = ((P > EXT_W) ? P : EXT_W) + 1;

    // Input field offsets inside s_tdata.
    localparam int OFF_CHROM  = 0;
    localparam int OFF_PF     = OFF_CHROM + CHROM_W;
    localparam int OFF_PL     = OFF_PF + P;
    localparam int OFF_MF     = OFF_PL + P;
    localparam int OFF_ML     = OFF_MF + P;
    localparam int OFF_RB     = OFF_ML + P;
    localparam int OFF_RE     = OFF_RB + P;
    localparam int OFF_STRAND = OFF_RE + P;
    localparam int OFF_LANE   = OFF_STRAND + 1;
    localparam int OFF_PAIR   = OFF_LANE + LANE_W;

    localparam int OUT_RAW_W  = ENTRY_NUM_W + KIND_W + 2 + LANE_W + PAIR_W;

    localparam logic [SUM_W-1:0] POS_MAX = SUM_W'({P{1'b1}});

    // Unpacked input fields.
    logic [CHROM_W-1:0] in_chrom;
    logic [P-1:0]       in_pf, in_pl, in_mf, in_ml, in_rb, in_re;
    logic               in_strand;
    logic [LANE_W-1:0]  in_lane;
    logic [PAIR_W-1:0]  in_pair;

    assign in_chrom  = s_tdata[OFF_CHROM +: CHROM_W];
    assign in_pf     = s_tdata[OFF_PF +: P];
    assign in_pl     = s_tdata[OFF_PL +: P];
    assign in_mf     = s_tdata[OFF_MF +: P];
    assign in_ml     = s_tdata[OFF_ML +: P];
    assign in_rb     = s_tdata[OFF_RB +: P];
    assign in_re     = s_tdata[OFF_RE +: P];
    assign in_strand = s_tdata[OFF_STRAND];
    assign in_lane   = s_tdata[OFF_LANE +: LANE_W];
    assign in_pair   = s_tdata[OFF_PAIR +: PAIR_W];

    // Control and configuration state.
    scan_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [EXT_W-1:0]   ext_reg;

    // Held query.
    logic [CHROM_W-1:0] q_chrom_reg;
    logic [P-1:0]       q_rb_reg, q_re_reg;
    logic               q_strand_reg;
    logic [LANE_W-1:0]  q_lane_reg;
    logic [PAIR_W-1:0]  q_pair_reg;
    logic               q_we;

    // Match held back until we know whether another one follows.
    logic               pend_v_reg, pend_v_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    match_kind_t        pend_kind_reg, pend_kind_next;

    // Result register.
    logic                   m_valid_reg, m_valid_next;
    logic [ENTRY_NUM_W-1:0] o_entry_reg, o_entry_next;
    match_kind_t            o_kind_reg, o_kind_next;
    logic                   o_lev_reg, o_lev_next;
    logic                   o_rev_reg, o_rev_next;
    logic [LANE_W-1:0]      o_lane_reg, o_lane_next;
    logic [PAIR_W-1:0]      o_pair_reg, o_pair_next;
    logic                   o_full_reg, o_full_next;
    logic                   o_last_reg, o_last_next;
    logic                   out_we;
    logic                   out_free;

    // Entry ring.
    logic [ENT_W-1:0]   cell_q [TABLE_DEPTH];
    logic [ENT_W-1:0]   new_entry;
    logic               ring_load;
    logic               ring_shift;
    logic [SUM_W-1:0]   pf_wide, ml_wide, ext_wide, diff_wide, sum_wide;
    logic [P-1:0]       new_llo, new_rhi;

    match_kind_t        head_kind;
    logic               head_valid;
    logic [1:0]         pend_events;

    assign out_free = !m_valid_reg || m_tready;

    // Saturating window bounds for a new entry.
    always_comb begin
        pf_wide   = SUM_W'(in_pf);
        ml_wide   = SUM_W'(in_ml);
        ext_wide  = SUM_W'(ext_reg);
        diff_wide = pf_wide - ext_wide;
        sum_wide  = ml_wide + ext_wide;
        new_llo   = (pf_wide >= ext_wide) ? diff_wide[P-1:0] : '0;
        new_rhi   = (sum_wide > POS_MAX) ? POS_MAX[P-1:0] : sum_wide[P-1:0];
        new_entry = {in_chrom, new_llo, in_pl, in_mf, new_rhi};
    end

    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
            cell_ctl_t cell_ctl;
            assign cell_ctl.load  = ring_load && (cnt_reg == CNT_W'(k));
            assign cell_ctl.shift = ring_shift;
            bwom_cell #(
                .DATA_W (ENT_W)
            ) u_cell (
                .aclk     (aclk),
                .ctl      (cell_ctl),
                .load_in  (new_entry),
                .shift_in (cell_q[(k + 1) % TABLE_DEPTH]),
                .entry_q  (cell_q[k])
            );
        end
    endgenerate

    // Compare the head cell; it holds entry step_reg during the scan.
    bwom_match #(
        .POSITION_BITS (P)
    ) u_match (
        .entry_chrom (cell_q[0][ENT_W-1 -: CHROM_W]),
        .left_low    (cell_q[0][4*P-1 -: P]),
        .left_high   (cell_q[0][3*P-1 -: P]),
        .right_low   (cell_q[0][2*P-1 -: P]),
        .right_high  (cell_q[0][P-1:0]),
        .read_chrom  (q_chrom_reg),
        .read_begin  (q_rb_reg),
        .read_end    (q_re_reg),
        .kind        (head_kind)
    );

    assign head_valid  = CNT_W'(step_reg) < cnt_reg;
    assign pend_events = event_flags(pend_kind_reg, q_strand_reg);

    // Next state and result selection.
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        pend_v_next    = pend_v_reg;
        pend_idx_next  = pend_idx_reg;
        pend_kind_next = pend_kind_reg;
        q_we           = 1'b0;
        ring_load      = 1'b0;
        ring_shift     = 1'b0;
        s_tready       = 1'b0;
        out_we         = 1'b0;
        o_entry_next   = '0;
        o_kind_next    = KIND_NONE;
        o_lev_next     = 1'b0;
        o_rev_next     = 1'b0;
        o_lane_next    = q_lane_reg;
        o_pair_next    = q_pair_reg;
        o_full_next    = 1'b0;
        o_last_next    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free) begin
                    if (s_tuser == CMD_LOAD) begin
                        // Answer a load at once; refuse it on a full table.
                        out_we      = 1'b1;
                        o_lane_next = '0;
                        o_pair_next = '0;
                        o_last_next = 1'b1;
                        if (cnt_reg == CNT_W'(TABLE_DEPTH)) begin
                            o_full_next = 1'b1;
                        end else begin
                            ring_load = 1'b1;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end else begin
                        q_we        = 1'b1;
                        step_next   = '0;
                        pend_v_next = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    ring_shift = 1'b1;
                    step_next  = step_reg + 1'b1;
                    if (head_valid && head_kind != KIND_NONE) begin
                        // Release the previous match, not the last one.
                        if (pend_v_reg) begin
                            out_we       = 1'b1;
                            o_entry_next = ENTRY_NUM_W'(pend_idx_reg);
                            o_kind_next  = pend_kind_reg;
                            o_lev_next   = pend_events[0];
                            o_rev_next   = pend_events[1];
                        end
                        pend_v_next    = 1'b1;
                        pend_idx_next  = step_reg;
                        pend_kind_next = head_kind;
                    end
                    if (step_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_we      = 1'b1;
                    o_last_next = 1'b1;
                    if (pend_v_reg) begin
                        o_entry_next = ENTRY_NUM_W'(pend_idx_reg);
                        o_kind_next  = pend_kind_reg;
                        o_lev_next   = pend_events[0];
                        o_rev_next   = pend_events[1];
                    end
                    pend_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_we) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            cnt_reg     <= '0;
            ext_reg     <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                ext_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pend_idx_reg  <= pend_idx_next;
        pend_kind_reg <= pend_kind_next;
        if (q_we) begin
            q_chrom_reg  <= in_chrom;
            q_rb_reg     <= in_rb;
            q_re_reg     <= in_re;
            q_strand_reg <= in_strand;
            q_lane_reg   <= in_lane;
            q_pair_reg   <= in_pair;
        end
        if (out_we) begin
            o_entry_reg <= o_entry_next;
            o_kind_reg  <= o_kind_next;
            o_lev_reg   <= o_lev_next;
            o_rev_reg   <= o_rev_next;
            o_lane_reg  <= o_lane_next;
            o_pair_reg  <= o_pair_next;
            o_full_reg  <= o_full_next;
            o_last_reg  <= o_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(64 - OUT_RAW_W)'(0), o_pair_reg, o_lane_reg, o_rev_reg, o_lev_reg,
                       o_kind_reg, o_entry_reg};
    assign m_tuser  = o_full_reg;
    assign m_tlast  = o_last_reg;

    // The table never holds more entries than it has cells.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A load answers with a single final result in the next cycle.
    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_LOAD) |=> (m_tvalid && m_tlast))
        else $error("load did not produce its result");

    // A kind-none result carries no entry and no event.
    a_none_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && o_kind_reg == KIND_NONE) |-> (o_entry_reg == '0 && !o_lev_reg && !o_rev_reg))
        else $error("kind none result with entry or event set");

    // The scan holds while the result register is blocked.
    a_scan_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !out_free) |=> $stable(step_reg))
        else $error("scan advanced during output stall");

    // No command is taken while a query is in progress.
    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_FINISH) |-> !s_tready)
        else $error("input accepted during scan");

endmodule

/* hw/rtl/bwom_cell.sv */
// One cell of the entry ring: holds one boundary entry, loads or shifts.
`timescale 1ns / 1ps
module bwom_cell #(
    parameter int DATA_W = 136
) (
    input  logic                 aclk,
    input  bwom_pkg::cell_ctl_t  ctl,
    input  logic [DATA_W-1:0]    load_in,
    input  logic [DATA_W-1:0]    shift_in,
    output logic [DATA_W-1:0]    entry_q
);
    import bwom_pkg::*;

    logic [DATA_W-1:0] entry_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            entry_reg <= load_in;
        end else if (ctl.shift) begin
            entry_reg <= shift_in;
        end
    end

    assign entry_q = entry_reg;

endmodule

/* hw/rtl/bwom_match.sv */
// Window compare of the read ends against the entry at the head of the ring.
`timescale 1ns / 1ps
module bwom_match #(
    parameter int POSITION_BITS = 32
) (
    input  logic [bwom_pkg::CHROM_W-1:0] entry_chrom,
    input  logic [POSITION_BITS-1:0]     left_low,
    input  logic [POSITION_BITS-1:0]     left_high,
    input  logic [POSITION_BITS-1:0]     right_low,
    input  logic [POSITION_BITS-1:0]     right_high,
    input  logic [bwom_pkg::CHROM_W-1:0] read_chrom,
    input  logic [POSITION_BITS-1:0]     read_begin,
    input  logic [POSITION_BITS-1:0]     read_end,
    output bwom_pkg::match_kind_t        kind
);
    import bwom_pkg::*;

    logic left_hit;
    logic right_hit;

    always_comb begin
        left_hit  = (read_begin >= left_low && read_begin <= left_high) ||
                    (read_end >= left_low && read_end <= left_high);
        right_hit = (read_begin >= right_low && read_begin <= right_high) ||
                    (read_end >= right_low && read_end <= right_high);
        if (entry_chrom != read_chrom) begin
            kind = KIND_NONE;
        end else if (left_hit && right_hit) begin
            kind = KIND_BOTH;
        end else if (left_hit) begin
            kind = KIND_LEFT;
        end else if (right_hit) begin
            kind = KIND_RIGHT;
        end else begin
            kind = KIND_NONE;
        end
    end

endmodule

/* sim/tb_boundary_window_overlap_match_core.sv */
// Self-checking testbench for the boundary window overlap matcher core.
`timescale 1ns / 1ps
module tb_boundary_window_overlap_match_core;
    import bwom_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int SLOT_W        = $clog2(TABLE_DEPTH);
    localparam int POSITION_BITS = 32;
    localparam int S_DATA_W      = ((CHROM_W + 6*POSITION_BITS + 1 + LANE_W + PAIR_W + 7) / 8) * 8;
    // Longest stretch without any transaction that a correct run can show is a
    // register pause plus one full ring scan plus stalls.
    localparam int STALL_LIMIT   = 4000;

    // One command as it travels on the input stream.
    typedef struct {
        logic               op;
        logic [CHROM_W-1:0] chrom;
        logic [31:0]        plus_first;
        logic [31:0]        plus_last;
        logic [31:0]        minus_first;
        logic [31:0]        minus_last;
        logic [31:0]        read_begin;
        logic [31:0]        read_end;
        logic               strand;
        logic [LANE_W-1:0]  lane;
        logic [PAIR_W-1:0]  pair;
    } command_t;

    // One result as it should appear on the output stream.
    typedef struct {
        logic [ENTRY_NUM_W-1:0] entry;
        match_kind_t            kind;
        logic                   left_ev;
        logic                   right_ev;
        logic [LANE_W-1:0]      lane;
        logic [PAIR_W-1:0]      pair;
        logic                   full;
        logic                   last;
    } outcome_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [31:0]         cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [63:0]         m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    boundary_window_overlap_match_core #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the boundary table and the extension register.
    logic [CHROM_W-1:0] tbl_chrom    [TABLE_DEPTH];
    logic [31:0]        tbl_left_lo  [TABLE_DEPTH];
    logic [31:0]        tbl_left_hi  [TABLE_DEPTH];
    logic [31:0]        tbl_right_lo [TABLE_DEPTH];
    logic [31:0]        tbl_right_hi [TABLE_DEPTH];
    int unsigned        stored_count = 0;
    logic [31:0]        window_ext = '0;

    command_t command_queue[$];
    outcome_t awaited_results[$];
    command_t current_cmd;

    // Coordinate anchors per chromosome so that random loads and queries overlap.
    logic [31:0] chrom_anchor [4] = '{32'h0000_0000, 32'h0001_0000, 32'h8000_1234, 32'hFFFF_E000};

    bit idle_on = 1'b1;
    int src_gap = 0;
    int sink_gap = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int loads_queued = 0;
    int n_loads = 0;
    int n_refused = 0;
    int n_queries = 0;
    int n_matches = 0;
    int n_results = 0;
    int n_settings = 0;

    // Predict the results of one accepted command and update the shadow table.
    function automatic void apply_command(command_t c);
        outcome_t    o;
        outcome_t    hits[$];
        logic [32:0] widened;
        logic [SLOT_W-1:0] slot;
        logic        lh;
        logic        rh;
        o.entry    = '0;
        o.kind     = KIND_NONE;
        o.left_ev  = 1'b0;
        o.right_ev = 1'b0;
        o.lane     = '0;
        o.pair     = '0;
        o.full     = 1'b0;
        o.last     = 1'b1;
        if (c.op == CMD_LOAD) begin
            n_loads++;
            if (stored_count >= TABLE_DEPTH) begin
                // Refuse: table is full, nothing stored.
                o.full = 1'b1;
                n_refused++;
            end else begin
                slot = stored_count[SLOT_W-1:0];
                tbl_chrom[slot]   = c.chrom;
                // Saturate the left window at zero.
                tbl_left_lo[slot] = (c.plus_first >= window_ext) ?
                                    c.plus_first - window_ext : '0;
                tbl_left_hi[slot] = c.plus_last;
                tbl_right_lo[slot] = c.minus_first;
                // Saturate the right window at the top coordinate.
                widened = {1'b0, c.minus_last} + {1'b0, window_ext};
                tbl_right_hi[slot] = widened[32] ? '1 : widened[31:0];
                stored_count++;
            end
            awaited_results = {awaited_results, o};
        end else begin
            n_queries++;
            o.lane = c.lane;
            o.pair = c.pair;
            for (int i = 0; i < stored_count; i++) begin
                slot = i[SLOT_W-1:0];
                if (tbl_chrom[slot] != c.chrom) continue;
                lh = (c.read_begin >= tbl_left_lo[slot] && c.read_begin <= tbl_left_hi[slot]) ||
                     (c.read_end >= tbl_left_lo[slot] && c.read_end <= tbl_left_hi[slot]);
                rh = (c.read_begin >= tbl_right_lo[slot] && c.read_begin <= tbl_right_hi[slot]) ||
                     (c.read_end >= tbl_right_lo[slot] && c.read_end <= tbl_right_hi[slot]);
                if (!lh && !rh) continue;
                o.entry    = slot;
                o.kind     = (lh && rh) ? KIND_BOTH : (lh ? KIND_LEFT : KIND_RIGHT);
                // Single-window hits only raise the flag that agrees with the strand.
                o.left_ev  = (o.kind == KIND_BOTH) ||
                             (o.kind == KIND_LEFT && c.strand == STRAND_FWD);
                o.right_ev = (o.kind == KIND_BOTH) ||
                             (o.kind == KIND_RIGHT && c.strand == STRAND_REV);
                o.last     = 1'b0;
                hits = {hits, o};
            end
            n_matches += hits.size();
            if (hits.size() == 0) begin
                // No match: one kind-none result carrying lane and pair.
                o.entry = '0;
                o.kind  = KIND_NONE;
                o.last  = 1'b1;
                hits = {hits, o};
            end
            hits[hits.size()-1].last = 1'b1;
            foreach (hits[k]) awaited_results = {awaited_results, hits[k]};
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic command_t load_cmd(logic [7:0] chrom, logic [31:0] pf, logic [31:0] pl,
                                          logic [31:0] mf, logic [31:0] ml);
        command_t c;
        c = '{op: CMD_LOAD, chrom: chrom, plus_first: pf, plus_last: pl, minus_first: mf,
              minus_last: ml, read_begin: '0, read_end: '0, strand: STRAND_FWD,
              lane: '0, pair: '0};
        return c;
    endfunction

    function automatic command_t query_cmd(logic [7:0] chrom, logic [31:0] rb, logic [31:0] re,
                                           logic strand, logic [15:0] lane, logic [31:0] pair);
        command_t c;
        c = '{op: CMD_QUERY, chrom: chrom, plus_first: '0, plus_last: '0, minus_first: '0,
              minus_last: '0, read_begin: rb, read_end: re, strand: strand,
              lane: lane, pair: pair};
        return c;
    endfunction

    // Mostly well-formed commands near a chromosome's anchor; the rest is raw noise.
    function automatic command_t random_command(int load_percent);
        command_t    c;
        logic [31:0] base;
        logic [31:0] tmp;
        c.op          = ($urandom_range(1, 100) <= load_percent) ? CMD_LOAD : CMD_QUERY;
        c.chrom       = CHROM_W'($urandom_range(0, 255));
        c.plus_first  = $urandom();
        c.plus_last   = $urandom();
        c.minus_first = $urandom();
        c.minus_last  = $urandom();
        c.read_begin  = $urandom();
        c.read_end    = $urandom();
        c.strand      = 1'($urandom_range(0, 1));
        c.lane        = LANE_W'($urandom_range(0, 65535));
        c.pair        = $urandom();
        if ($urandom_range(0, 5) == 0) return c;
        c.chrom = CHROM_W'($urandom_range(0, 3));
        base    = chrom_anchor[c.chrom[1:0]];
        if (c.op == CMD_LOAD) begin
            c.plus_first  = base + $urandom_range(0, 3000);
            c.plus_last   = c.plus_first + $urandom_range(0, 300);
            c.minus_first = c.plus_last + $urandom_range(0, 300);
            c.minus_last  = c.minus_first + $urandom_range(0, 300);
            // Now and then turn a window inside out so it stays empty unless
            // the extension reopens it.
            if ($urandom_range(0, 7) == 0) begin
                tmp = c.plus_first; c.plus_first = c.plus_last + 1; c.plus_last = tmp;
            end
            if ($urandom_range(0, 7) == 0) begin
                tmp = c.minus_first; c.minus_first = c.minus_last + 1; c.minus_last = tmp;
            end
        end else begin
            c.read_begin = base + $urandom_range(0, 4000);
            c.read_end   = c.read_begin + $urandom_range(0, 200);
        end
        return c;
    endfunction

    task automatic enqueue(command_t c);
        if (c.op == CMD_LOAD) loads_queued++;
        command_queue = {command_queue, c};
    endtask

    // Hold until every command is taken and answered, then let the core drain.
    task automatic settle();
        while (command_queue.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (TABLE_DEPTH + 8) @(posedge aclk);
    endtask

    task automatic write_extension(logic [31:0] value);
        settle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        window_ext  = value;
        n_settings++;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Input driver: hold the current transaction until taken, then advance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) apply_command(current_cmd);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_on && command_queue.size() != 0 && $urandom_range(0, 5) == 0) begin
                    // Insert an idle burst that begins in this slot.
                    src_gap = $urandom_range(0, 13);
                    s_tvalid <= 1'b0;
                end else if (command_queue.size() != 0) begin
                    current_cmd = command_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= current_cmd.op;
                    s_tdata  <= S_DATA_W'({current_cmd.pair, current_cmd.lane, current_cmd.strand,
                                           current_cmd.read_end, current_cmd.read_begin,
                                           current_cmd.minus_last, current_cmd.minus_first,
                                           current_cmd.plus_last, current_cmd.plus_first,
                                           current_cmd.chrom});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result backpressure: random stall bursts while idling is enabled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            sink_gap = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor: compare each transaction with the oldest expectation.
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (awaited_results.size() == 0) begin
                $error("unexpected result transaction: tdata 0x%0h tuser %0b tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("entry_number", 32'(want.entry),    32'(m_tdata[5:0]));
                check_field("match_kind",   32'(want.kind),     32'(m_tdata[7:6]));
                check_field("left_event",   32'(want.left_ev),  32'(m_tdata[8]));
                check_field("right_event",  32'(want.right_ev), 32'(m_tdata[9]));
                check_field("lane_out",     32'(want.lane),     32'(m_tdata[25:10]));
                check_field("pair_out",     want.pair,          m_tdata[57:26]);
                check_field("table_full",   32'(want.full),     32'(m_tuser));
                check_field("last_result",  32'(want.last),     32'(m_tlast));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d cycles without a transaction, %0d results outstanding",
                     quiet_cycles, awaited_results.size());
            $display("tb_boundary_window_overlap_match_core: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Query on an empty table: must answer kind none.
        enqueue(query_cmd(8'd0, 32'd10, 32'd20, STRAND_FWD, 16'h1234, 32'hCAFE_0001));

        // Widest extension: both windows saturate.
        write_extension(32'hFFFF_FFFF);
        enqueue(load_cmd(8'd0, 32'd5, 32'd100, 32'd200, 32'hFFFF_FF00));
        enqueue(load_cmd(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0));
        enqueue(query_cmd(8'd0, 32'd0, 32'd0, STRAND_FWD, 16'h0000, 32'h0000_0000));
        enqueue(query_cmd(8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, STRAND_REV, 16'h00FF, 32'h1));
        enqueue(query_cmd(8'd255, 32'h8000_0000, 32'd7, STRAND_REV, 16'hFFFF, 32'hFFFF_FFFF));
        enqueue(query_cmd(8'd7, 32'd50, 32'd60, STRAND_FWD, 16'hA5A5, 32'h5A5A_5A5A));

        // No extension: exact window edges, empty windows, overlapping windows.
        write_extension(32'd0);
        enqueue(load_cmd(8'd1, 32'd1000, 32'd2000, 32'd3000, 32'd4000));
        enqueue(load_cmd(8'd1, 32'd500, 32'd400, 32'd5000, 32'd4500));
        enqueue(load_cmd(8'd1, 32'd1500, 32'd3500, 32'd1800, 32'd2500));
        enqueue(query_cmd(8'd1, 32'd1000, 32'd1000, STRAND_FWD, 16'd1, 32'd11));
        enqueue(query_cmd(8'd1, 32'd2000, 32'd4000, STRAND_REV, 16'd2, 32'd12));
        enqueue(query_cmd(8'd1, 32'd999, 32'd4001, STRAND_FWD, 16'd3, 32'd13));
        enqueue(query_cmd(8'd1, 32'd3000, 32'd2999, STRAND_REV, 16'd4, 32'd14));
        enqueue(query_cmd(8'd1, 32'd450, 32'd450, STRAND_FWD, 16'd5, 32'd15));
        enqueue(query_cmd(8'd1, 32'd4500, 32'd4500, STRAND_REV, 16'd6, 32'd16));

        // Random phases under different extensions.
        write_extension($urandom_range(1, 3000));
        repeat (50) enqueue(random_command(55));
        write_extension($urandom_range(3001, 200000));
        repeat (40) enqueue(random_command(55));
        write_extension($urandom());
        repeat (15) enqueue(random_command(55));

        // Last part without idling; fill the table past its depth.
        write_extension($urandom_range(0, 500));
        idle_on = 1'b0;
        repeat (30) enqueue(random_command(55));
        while (loads_queued < TABLE_DEPTH + 3) enqueue(random_command(100));
        repeat (3) enqueue(random_command(0));

        settle();
        $display("covered %0d loads (%0d refused on a full table) and %0d queries", n_loads,
                 n_refused, n_queries);
        $display("checked %0d result transactions, %0d entry matches, %0d extension settings",
                 n_results, n_matches, n_settings);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("tb_boundary_window_overlap_match_core: PASS");
        end else begin
            $display("tb_boundary_window_overlap_match_core: FAIL");
        end
        $finish;
    end

endmodule
